/* rtl/gwa_pkg.sv */
// ----------------------------------------------------------------------------
// Graph adjacency store package
// Transaction types, operation and status codes, name trimming shared by
// the graph store modules.
// ----------------------------------------------------------------------------
package gwa_pkg;

	localparam int NAME_W     = 64;
	localparam int NAME_BYTES = 8;

	localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
	localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
	localparam logic [1:0] OP_EDGE_QUERY = 2'd2;
	localparam logic [1:0] OP_DEGREE     = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD     = 3'd1;
	localparam logic [2:0] ST_MISSING = 3'd2;
	localparam logic [2:0] ST_DUP     = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	localparam logic [6:0] WEIGHT_MIN = 7'd1;
	localparam logic [6:0] WEIGHT_MAX = 7'd100;

	// Saturation limits of the result count fields
	localparam int DEGREE_LIMIT = 15;
	localparam int VERTEX_LIMIT = 31;
	localparam int EDGE_LIMIT   = 127;

	typedef struct packed {
		logic [1:0]        operation;
		logic [NAME_W-1:0] first_name;
		logic [NAME_W-1:0] second_name;
		logic [6:0]        weight;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic       edge_present;
		logic [3:0] vertex_degree;
		logic [4:0] vertices_held;
		logic [6:0] edges_held;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [NAME_W-1:0] name_a;
		logic [NAME_W-1:0] name_b;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic hit_a;
		logic hit_b;
	} scan_rsp_t;

	// Keep the significant bytes up to the first zero byte, drop the rest
	function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] trimmed;
		logic              alive;
		logic [7:0]        ch;
		trimmed = '0;
		alive   = 1'b1;
		for (int b = 0; b < 8; b++) begin
			ch = raw[NAME_W-1-8*b -: 8];
			if (b >= NAME_BYTES || ch == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				trimmed[NAME_W-1-8*b -: 8] = ch;
			end
		end
		return trimmed;
	endfunction

endpackage

/* rtl/gwa_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/gwa_scan.sv */
// ----------------------------------------------------------------------------
// Vertex name scan
// Holds the name memory and walks the occupied slots one per cycle,
// matching two names at once.
// ----------------------------------------------------------------------------
module gwa_scan #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gwa_pkg::scan_req_t                  req,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   count,
	input  logic                                wr_en,
	input  logic [$clog2(MAX_VERTICES)-1:0]     wr_slot,
	input  logic [gwa_pkg::NAME_W-1:0]          wr_name,
	output gwa_pkg::scan_rsp_t                  rsp,
	output logic [$clog2(MAX_VERTICES)-1:0]     slot_a,
	output logic [$clog2(MAX_VERTICES)-1:0]     slot_b
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int VW = $clog2(MAX_VERTICES + 1);

	logic                       busy_q;
	logic [IW-1:0]              idx_q;
	logic                       valid_s1;
	logic                       last_s1;
	logic [IW-1:0]              slot_s1;
	logic                       done_q;
	logic                       hit_a_q;
	logic                       hit_b_q;
	logic [IW-1:0]              slot_a_q;
	logic [IW-1:0]              slot_b_q;
	logic [gwa_pkg::NAME_W-1:0] rd_name;
	logic                       idx_last;

	gwa_ram #(
		.WIDTH(gwa_pkg::NAME_W),
		.DEPTH(MAX_VERTICES)
	) u_name_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_slot),
		.wdata(wr_name),
		.raddr(idx_q),
		.rdata(rd_name)
	);

	assign idx_last = (VW'(idx_q) == count - VW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			hit_a_q  <= 1'b0;
			hit_b_q  <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
			last_s1  <= busy_q && idx_last;
			done_q   <= (valid_s1 && last_s1) || (req.start && count == '0);
			if (req.start) begin
				hit_a_q <= 1'b0;
				hit_b_q <= 1'b0;
				idx_q   <= '0;
				busy_q  <= (count != '0);
			end else if (busy_q) begin
				// stop issuing reads after the last occupied slot
				if (idx_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (valid_s1 && !hit_a_q && rd_name == req.name_a) begin
				hit_a_q <= 1'b1;
			end
			if (valid_s1 && !hit_b_q && rd_name == req.name_b) begin
				hit_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		if (valid_s1 && !hit_a_q && rd_name == req.name_a) begin
			slot_a_q <= slot_s1;
		end
		if (valid_s1 && !hit_b_q && rd_name == req.name_b) begin
			slot_b_q <= slot_s1;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.hit_a = hit_a_q;
	assign rsp.hit_b = hit_b_q;
	assign slot_a    = slot_a_q;
	assign slot_b    = slot_b_q;

endmodule

/* rtl/weighted_graph_adjacency_store.sv */
// Flow: a check rejects bad operations early; otherwise a name scan reads one stored
// name per cycle over the N vertices held and settles the result, or an adjacency or
// degree read follows; an added edge then writes both adjacency entries and degrees.
// Throughput: one operation at a time; the next is taken once the result is in the
// output register. Reset clears counts and control, then clears the adjacency
// memory entry by entry with cmd_stall high.
// ----------------------------------------------------------------------------
// Weighted graph adjacency store
// Undirected weighted graph with named vertices: add vertex, add edge, edge
// query and degree query over a name memory, adjacency memory and degree memory.
// ----------------------------------------------------------------------------
module weighted_graph_adjacency_store #(
	parameter int MAX_VERTICES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  gwa_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output gwa_pkg::res_t res
);

	localparam int IW        = $clog2(MAX_VERTICES);
	localparam int VW        = $clog2(MAX_VERTICES + 1);
	localparam int DW        = IW;
	localparam int EW        = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
	localparam int ADJ_DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW        = $clog2(ADJ_DEPTH);

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_CHECK    = 9'b000000100,
		S_SCAN     = 9'b000001000,
		S_ADJ      = 9'b000010000,
		S_EDGE_B   = 9'b000100000,
		S_EDGE_DEG = 9'b001000000,
		S_DEG      = 9'b010000000,
		S_FINISH   = 9'b100000000
	} state_t;

	state_t                     state_q;
	logic [1:0]                 op_q;
	logic [gwa_pkg::NAME_W-1:0] name_a_q;
	logic [gwa_pkg::NAME_W-1:0] name_b_q;
	logic [6:0]                 weight_q;
	logic [2:0]                 status_q;
	logic                       present_q;
	logic [DW-1:0]              degree_q;
	logic [VW-1:0]              vcount_q;
	logic [EW-1:0]              ecount_q;
	logic [AW-1:0]              clr_q;
	logic                       res_valid_q;
	gwa_pkg::res_t              res_q;

	gwa_pkg::scan_req_t scan_req;
	gwa_pkg::scan_rsp_t scan_rsp;
	logic [IW-1:0]      slot_a;
	logic [IW-1:0]      slot_b;

	logic          early_bad;
	logic          table_full;
	logic          vertex_add;
	logic          res_free;
	logic          adj_we;
	logic [AW-1:0] adj_waddr;
	logic [6:0]    adj_wdata;
	logic [AW-1:0] adj_raddr;
	logic [6:0]    adj_rdata;
	logic          deg_we;
	logic [IW-1:0] deg_waddr;
	logic [DW-1:0] deg_wdata;
	logic [IW-1:0] deg_raddr;
	logic [DW-1:0] deg_rdata;
	gwa_pkg::res_t res_next;

	function automatic logic [AW-1:0] adj_addr(input logic [IW-1:0] r,
		input logic [IW-1:0] c);
		return AW'(32'(r) * MAX_VERTICES + 32'(c));
	endfunction

	assign early_bad = (op_q == gwa_pkg::OP_ADD_VERTEX && name_a_q == '0) ||
		(op_q == gwa_pkg::OP_ADD_EDGE && (weight_q < gwa_pkg::WEIGHT_MIN ||
		weight_q > gwa_pkg::WEIGHT_MAX || name_a_q == name_b_q));
	assign table_full = (vcount_q == VW'(MAX_VERTICES));
	assign vertex_add = (state_q == S_SCAN) && scan_rsp.done &&
		(op_q == gwa_pkg::OP_ADD_VERTEX) && !scan_rsp.hit_a && !table_full;
	assign res_free   = !res_valid_q || !res_stall;

	assign scan_req.start  = (state_q == S_CHECK) && !early_bad;
	assign scan_req.name_a = name_a_q;
	assign scan_req.name_b = name_b_q;

	gwa_scan #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scan_req),
		.count  (vcount_q),
		.wr_en  (vertex_add),
		.wr_slot(IW'(vcount_q)),
		.wr_name(name_a_q),
		.rsp    (scan_rsp),
		.slot_a (slot_a),
		.slot_b (slot_b)
	);

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = adj_addr(slot_a, slot_b);
		adj_wdata = weight_q;
		case (state_q)
			S_CLEAR: begin
				adj_we    = 1'b1;
				adj_waddr = clr_q;
				adj_wdata = '0;
			end
			S_ADJ: begin
				adj_we = (op_q == gwa_pkg::OP_ADD_EDGE) && (adj_rdata == '0);
			end
			S_EDGE_B: begin
				adj_we    = 1'b1;
				adj_waddr = adj_addr(slot_b, slot_a);
			end
			default: begin
			end
		endcase
	end

	assign adj_raddr = adj_addr(slot_a, slot_b);

	gwa_ram #(
		.WIDTH(7),
		.DEPTH(ADJ_DEPTH)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	always_comb begin
		deg_we    = 1'b0;
		deg_waddr = slot_a;
		deg_wdata = deg_rdata + DW'(1);
		case (state_q)
			S_SCAN: begin
				// a new vertex starts with no neighbors
				deg_we    = vertex_add;
				deg_waddr = IW'(vcount_q);
				deg_wdata = '0;
			end
			S_EDGE_B: begin
				deg_we = 1'b1;
			end
			S_EDGE_DEG: begin
				deg_we    = 1'b1;
				deg_waddr = slot_b;
			end
			default: begin
			end
		endcase
	end

	assign deg_raddr = (state_q == S_EDGE_B) ? slot_b : slot_a;

	gwa_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_VERTICES)
	) u_deg_ram (
		.clk  (clk),
		.we   (deg_we),
		.waddr(deg_waddr),
		.wdata(deg_wdata),
		.raddr(deg_raddr),
		.rdata(deg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			vcount_q <= '0;
			ecount_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ADJ_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= early_bad ? S_FINISH : S_SCAN;
				end
				S_SCAN: begin
					if (scan_rsp.done) begin
						if (op_q == gwa_pkg::OP_ADD_VERTEX) begin
							state_q <= S_FINISH;
							if (vertex_add) begin
								vcount_q <= vcount_q + VW'(1);
							end
						end else if (!scan_rsp.hit_a) begin
							state_q <= S_FINISH;
						end else if (op_q == gwa_pkg::OP_DEGREE) begin
							state_q <= S_DEG;
						end else if (!scan_rsp.hit_b) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_ADJ;
						end
					end
				end
				S_ADJ: begin
					if (op_q == gwa_pkg::OP_ADD_EDGE && adj_rdata == '0) begin
						state_q <= S_EDGE_B;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_EDGE_B: begin
					state_q <= S_EDGE_DEG;
				end
				S_EDGE_DEG: begin
					ecount_q <= ecount_q + EW'(1);
					state_q  <= S_FINISH;
				end
				S_DEG: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= cmd.operation;
				name_a_q  <= gwa_pkg::trim_name(cmd.first_name);
				name_b_q  <= gwa_pkg::trim_name(cmd.second_name);
				weight_q  <= cmd.weight;
				status_q  <= gwa_pkg::ST_OK;
				present_q <= 1'b0;
				degree_q  <= '0;
			end
			S_CHECK: begin
				if (early_bad) begin
					status_q <= gwa_pkg::ST_BAD;
				end
			end
			S_SCAN: begin
				if (scan_rsp.done) begin
					if (op_q == gwa_pkg::OP_ADD_VERTEX) begin
						if (scan_rsp.hit_a) begin
							status_q <= gwa_pkg::ST_DUP;
						end else if (table_full) begin
							status_q <= gwa_pkg::ST_FULL;
						end
					end else if (!scan_rsp.hit_a) begin
						status_q <= gwa_pkg::ST_MISSING;
					end else if (op_q inside {gwa_pkg::OP_ADD_EDGE,
						gwa_pkg::OP_EDGE_QUERY} && !scan_rsp.hit_b) begin
						status_q <= gwa_pkg::ST_MISSING;
					end
				end
			end
			S_ADJ: begin
				if (op_q == gwa_pkg::OP_EDGE_QUERY) begin
					present_q <= (adj_rdata != '0);
				end else if (adj_rdata != '0) begin
					status_q <= gwa_pkg::ST_DUP;
				end
			end
			S_DEG: begin
				degree_q <= deg_rdata;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_next.status        = status_q;
		res_next.edge_present  = present_q;
		res_next.vertex_degree = (32'(degree_q) > gwa_pkg::DEGREE_LIMIT) ?
			4'(gwa_pkg::DEGREE_LIMIT) : 4'(degree_q);
		res_next.vertices_held = (32'(vcount_q) > gwa_pkg::VERTEX_LIMIT) ?
			5'(gwa_pkg::VERTEX_LIMIT) : 5'(vcount_q);
		res_next.edges_held    = (32'(ecount_q) > gwa_pkg::EDGE_LIMIT) ?
			7'(gwa_pkg::EDGE_LIMIT) : 7'(ecount_q);
	end

	// Output register: hold until taken, reload while the old transaction leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && res_free) begin
			res_q <= res_next;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rsp.done |-> state_q == S_SCAN)
		else $error("name scan finished outside the scan state");

	a_vertex_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= VW'(MAX_VERTICES))
		else $error("vertex count beyond table size");

	a_edge_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EDGE_DEG |=> ecount_q == $past(ecount_q) + EW'(1))
		else $error("edge count not advanced by an added edge");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside the finish state");

endmodule
